### rtl/gptc_pkg.sv
`default_nettype none

package gptc_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_LOAD   = 4'b1000
	} state_t;

	// Field widths
	localparam int unsigned SAMPLE_W    = 12;
	localparam int unsigned THR_W       = 12;
	localparam int unsigned WIN_W       = 24;
	localparam int unsigned PHASE_W     = 2;
	localparam int unsigned TERRAIN_W   = 3;
	localparam int unsigned PCT_W       = 7;
	localparam int unsigned CFG_W       = 24;
	localparam int unsigned CFG_ADDR_W  = 1;
	localparam int unsigned IN_TDATA_W  = 96;
	localparam int unsigned OUT_TDATA_W = 64;
	localparam int unsigned OUT_USED_W  = 58;

	// Gait phase codes
	localparam logic [PHASE_W-1:0] PH_STANCE      = 2'd0;
	localparam logic [PHASE_W-1:0] PH_HEEL_OFF    = 2'd1;
	localparam logic [PHASE_W-1:0] PH_SWING       = 2'd2;
	localparam logic [PHASE_W-1:0] PH_HEEL_STRIKE = 2'd3;

	// Terrain codes
	localparam logic [TERRAIN_W-1:0] TR_DESCENDING  = 3'd0;
	localparam logic [TERRAIN_W-1:0] TR_ASCENDING   = 3'd1;
	localparam logic [TERRAIN_W-1:0] TR_LEVEL       = 3'd2;
	localparam logic [TERRAIN_W-1:0] TR_UNDECIDED   = 3'd3;
	localparam logic [TERRAIN_W-1:0] TR_OUT_OF_BAND = 3'd4;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_WINDOW = 1'b1;

	// Reset values and decision limits
	localparam logic [THR_W-1:0] THRESHOLD_RESET  = 12'd3900;
	localparam logic [WIN_W-1:0] MIN_WINDOW_RESET = 24'd1023;
	localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;
	localparam logic [PCT_W-1:0] SWING_LOW        = 7'd30;
	localparam logic [PCT_W-1:0] SWING_HIGH       = 7'd60;
	localparam logic [PCT_W-1:0] HEEL_OFF_MIN     = 7'd15;
	localparam logic [PCT_W-1:0] STRIKE_MAX       = 7'd10;
	localparam logic [PCT_W-1:0] STRIKE_NONE      = 7'd1;
	localparam logic [PCT_W:0]   STANCE_MARGIN    = 8'd30;

	// Last divider step index per percentage (quotient never exceeds 100)
	localparam logic [2:0] LAST_STEP = 3'd6;

endpackage

`default_nettype wire

### rtl/gait_phase_terrain_classifier.sv
`default_nettype none
// An accepted frame goes through EVAL, then DIVIDE when it closes a window, then LOAD.
// A new frame is taken only in IDLE, once the last result is in the output register; the
//   shared 7-step restoring divider forms the four percentages one after another.
// Output stalls add cycles only once a finished result cannot enter the output register.
// Reset (arst_n low, asynchronous): counters and the non-swing flag clear, registers return
//   to threshold 3900 and minimum window 1023, the output register empties.
module gait_phase_terrain_classifier
	import gptc_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration write port
	input  wire                          cfg_we,
	input  wire  [CFG_ADDR_W-1:0]        cfg_addr,
	input  wire  [CFG_W-1:0]             cfg_wdata,
	// frame input
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// s_tdata from bit 0: front_a, front_b, front_c, middle_a, middle_b,
	// back_a, back_b, back_c (12 bits each)
	input  wire  [IN_TDATA_W-1:0]        s_tdata,
	// result output
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// m_tdata from bit 0: phase(2), decision_valid(1), terrain(3), swing_pct(7),
	// stance_pct(7), heel_off_pct(7), heel_strike_pct(7), window_count(24), zero pad(6)
	output logic [OUT_TDATA_W-1:0]       m_tdata
);

	localparam int unsigned TOT_W  = COUNT_WIDTH + 2;   // sum of four counters
	localparam int unsigned REM_W  = COUNT_WIDTH + 7;   // part * 100
	localparam int unsigned DVS_W  = COUNT_WIDTH + 8;   // total << 6
	localparam int unsigned WIDE_W = (TOT_W > WIN_W) ? TOT_W : WIN_W;

	// Configuration registers
	logic [THR_W-1:0] threshold_q;
	logic [WIN_W-1:0] min_window_q;

	// Phase counters and window flag
	logic [COUNT_WIDTH-1:0] stance_q, heel_off_q, swing_q, heel_strike_q;
	logic                   non_swing_q;

	// Sequencer and divider
	state_t             state_q;
	logic [PHASE_W-1:0] phase_q;
	logic               dec_q;
	logic [TOT_W-1:0]   total_q;
	logic [REM_W-1:0]   rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [PCT_W-1:0]   quo_q;
	logic [2:0]         step_q;
	logic [1:0]         idx_q;
	logic [PCT_W-1:0]   pct_q [4];

	// Phase classification of the incoming frame
	logic [SAMPLE_W+1:0] front_sum, back_sum, thr3;
	logic [SAMPLE_W:0]   middle_sum;
	logic                fh, mh, bh;
	logic [PHASE_W-1:0]  phase_d;
	logic                accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		front_sum  = (SAMPLE_W+2)'(s_tdata[11:0]) + (SAMPLE_W+2)'(s_tdata[23:12])
			+ (SAMPLE_W+2)'(s_tdata[35:24]);
		middle_sum = (SAMPLE_W+1)'(s_tdata[47:36]) + (SAMPLE_W+1)'(s_tdata[59:48]);
		back_sum   = (SAMPLE_W+2)'(s_tdata[71:60]) + (SAMPLE_W+2)'(s_tdata[83:72])
			+ (SAMPLE_W+2)'(s_tdata[95:84]);
		// floor(sum / 3) > t  is the same as  sum >= 3t + 3
		thr3 = {1'b0, threshold_q, 1'b0} + (SAMPLE_W+2)'(threshold_q) + (SAMPLE_W+2)'(3);
		fh   = (front_sum >= thr3);
		mh   = (middle_sum[SAMPLE_W:1] > threshold_q);
		bh   = (back_sum >= thr3);
		if (fh && mh && bh) begin
			phase_d = PH_SWING;
		end else if (fh && mh && !bh) begin
			phase_d = PH_HEEL_STRIKE;
		end else if ((!mh && !bh) || (!fh && mh && !bh)) begin
			phase_d = PH_STANCE;
		end else begin
			phase_d = PH_HEEL_OFF;
		end
	end

	// Window total and decision
	logic [TOT_W-1:0]  total_d;
	logic [WIDE_W-1:0] total_w;
	logic              dec_d;

	assign total_d = TOT_W'(stance_q) + TOT_W'(heel_off_q) + TOT_W'(swing_q)
		+ TOT_W'(heel_strike_q);
	assign total_w = WIDE_W'(total_q);
	assign dec_d   = (phase_q == PH_SWING) && non_swing_q
		&& (WIDE_W'(total_d) > WIDE_W'(min_window_q));

	// Counter feeding the divider: stance first, then by phase code
	logic [1:0]             sel_idx;
	logic [COUNT_WIDTH-1:0] cnt_sel;
	logic [REM_W-1:0]       cnt_x100;

	always_comb begin
		sel_idx = (state_q == ST_EVAL) ? 2'd0 : idx_q + 2'd1;
		case (sel_idx)
			PH_STANCE:      cnt_sel = stance_q;
			PH_HEEL_OFF:    cnt_sel = heel_off_q;
			PH_SWING:       cnt_sel = swing_q;
			PH_HEEL_STRIKE: cnt_sel = heel_strike_q;
			default:        cnt_sel = stance_q;
		endcase
		cnt_x100 = (REM_W'(cnt_sel) << 6) + (REM_W'(cnt_sel) << 5) + (REM_W'(cnt_sel) << 2);
	end

	// One restoring divider step
	logic             div_ge;
	logic [REM_W-1:0] rem_nxt;
	logic [PCT_W-1:0] quo_nxt;

	assign div_ge  = ({1'b0, rem_q} >= dvs_q);
	assign rem_nxt = div_ge ? rem_q - dvs_q[REM_W-1:0] : rem_q;
	assign quo_nxt = {quo_q[PCT_W-2:0], div_ge};

	// Terrain from the stored percentages
	logic [PCT_W-1:0]     sw, st, ho, hs;
	logic [TERRAIN_W-1:0] terrain;
	logic [WIN_W-1:0]     window_count;
	logic [OUT_TDATA_W-1:0] result;

	always_comb begin
		st = pct_q[PH_STANCE];
		ho = pct_q[PH_HEEL_OFF];
		sw = pct_q[PH_SWING];
		hs = pct_q[PH_HEEL_STRIKE];
		if (sw > SWING_LOW && sw < SWING_HIGH) begin
			if (hs < STRIKE_NONE && ho > HEEL_OFF_MIN) begin
				terrain = TR_DESCENDING;
			end else if (hs < STRIKE_MAX) begin
				// stance ahead of heel-off by more than the margin
				terrain = ({1'b0, st} > {1'b0, ho} + STANCE_MARGIN) ? TR_ASCENDING : TR_LEVEL;
			end else begin
				terrain = TR_UNDECIDED;
			end
		end else begin
			terrain = TR_OUT_OF_BAND;
		end
		window_count = (total_w > WIDE_W'({WIN_W{1'b1}})) ? {WIN_W{1'b1}}
			: total_w[WIN_W-1:0];
		if (dec_q) begin
			result = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, window_count, hs, ho, st, sw,
				terrain, 1'b1, phase_q};
		end else begin
			result = {{(OUT_TDATA_W-PHASE_W){1'b0}}, phase_q};
		end
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RESET;
			min_window_q  <= MIN_WINDOW_RESET;
			stance_q      <= '0;
			heel_off_q    <= '0;
			swing_q       <= '0;
			heel_strike_q <= '0;
			non_swing_q   <= 1'b0;
			state_q       <= ST_IDLE;
			m_tvalid      <= 1'b0;
			step_q        <= '0;
			idx_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_THRESHOLD:  threshold_q  <= cfg_wdata[THR_W-1:0];
					REG_MIN_WINDOW: min_window_q <= cfg_wdata[WIN_W-1:0];
					default: ;
				endcase
			end
			// raise on a loaded result, drop once the beat is taken
			if (state_q == ST_LOAD && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// count the frame, saturating
						case (phase_d)
							PH_STANCE:
								if (stance_q != '1) stance_q <= stance_q + 1'b1;
							PH_HEEL_OFF:
								if (heel_off_q != '1) heel_off_q <= heel_off_q + 1'b1;
							PH_SWING:
								if (swing_q != '1) swing_q <= swing_q + 1'b1;
							PH_HEEL_STRIKE:
								if (heel_strike_q != '1) heel_strike_q <= heel_strike_q + 1'b1;
							default: ;
						endcase
						if (phase_d != PH_SWING) begin
							non_swing_q <= 1'b1;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					step_q  <= '0;
					idx_q   <= '0;
					state_q <= dec_d ? ST_DIVIDE : ST_LOAD;
				end
				ST_DIVIDE: begin
					if (step_q == LAST_STEP) begin
						step_q <= '0;
						idx_q  <= idx_q + 2'd1;
						if (idx_q == PH_HEEL_STRIKE) begin
							state_q <= ST_LOAD;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_LOAD: begin
					// hold until the output register can take the result
					if (out_free) begin
						if (dec_q) begin
							stance_q      <= '0;
							heel_off_q    <= '0;
							swing_q       <= '0;
							heel_strike_q <= '0;
							non_swing_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					phase_q <= phase_d;
				end
			end
			ST_EVAL: begin
				dec_q   <= dec_d;
				total_q <= total_d;
				rem_q   <= cnt_x100;
				dvs_q   <= DVS_W'(total_d) << 6;
				quo_q   <= '0;
			end
			ST_DIVIDE: begin
				if (step_q == LAST_STEP) begin
					pct_q[idx_q] <= quo_nxt;
					// load the next counter
					rem_q <= cnt_x100;
					dvs_q <= DVS_W'(total_q) << 6;
					quo_q <= '0;
				end else begin
					rem_q <= rem_nxt;
					dvs_q <= dvs_q >> 1;
					quo_q <= quo_nxt;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					m_tdata <= result;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// Partial remainder stays below twice the shifted divisor
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> ({2'b00, rem_q} < {dvs_q, 1'b0}))
		else $error("divider remainder out of bound");

	// A percentage never exceeds one hundred when the output is loaded
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && dec_q) |-> (sw <= PCT_FULL && st <= PCT_FULL
			&& ho <= PCT_FULL && hs <= PCT_FULL))
		else $error("percentage above 100");

	// A decision closes only on a swing frame over a window that exceeds the minimum
	a_dec_swing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && dec_d) |-> (phase_q == PH_SWING && total_d != '0))
		else $error("decision on a non-swing frame or empty window");

	// Without a decision only the phase is nonzero
	a_no_dec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[PHASE_W]) |-> (m_tdata[OUT_TDATA_W-1:PHASE_W+1] == '0))
		else $error("result fields set without a decision");

	// Counters clear after a window is delivered
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && out_free && dec_q) |=> (total_d == '0 && !non_swing_q))
		else $error("counters not cleared after a window");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gptc_pkg::*;

	localparam int unsigned COUNT_W        = 24;
	localparam int unsigned SAMPLE_MAX     = 4095;
	localparam int unsigned SETTLE_CYCLES  = 40;    // covers the longest path, through the divider on a window close
	localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
	localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off for the backpressure test
	localparam int unsigned PHASE_ITEMS    = 180;
	localparam logic [THR_W-1:0] THR_MID   = 12'd2000;

	// eight samples, front_a in the lowest bits, same order as s_tdata
	typedef logic [7:0][SAMPLE_W-1:0] foot_frame_t;

	// same layout as m_tdata[OUT_USED_W-1:0]; the first member is the top
	typedef struct packed {
		logic [WIN_W-1:0]     window_count;
		logic [PCT_W-1:0]     heel_strike_pct;
		logic [PCT_W-1:0]     heel_off_pct;
		logic [PCT_W-1:0]     stance_pct;
		logic [PCT_W-1:0]     swing_pct;
		logic [TERRAIN_W-1:0] terrain;
		logic                 decided;
		logic [PHASE_W-1:0]   phase;
	} gait_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // front_a, front_b, front_c, middle_a, middle_b,
	                                         // back_a, back_b, back_c (12 bits each)
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // phase, decision_valid, terrain, swing_pct,
	                                         // stance_pct, heel_off_pct, heel_strike_pct,
	                                         // window_count, zero pad

	// Shadow of the block: registers, phase counters and the non-swing flag
	logic [THR_W-1:0]   thr_model;
	logic [WIN_W-1:0]   min_window_model;
	logic [COUNT_W-1:0] stance_cnt, heel_off_cnt, swing_cnt, heel_strike_cnt;
	bit                 grounded_seen;

	gait_result_t pending_results[$];  // expected result beats, oldest first
	foot_frame_t  frames_out[$];       // frames waiting for the driver
	foot_frame_t  frame_on_bus;
	bit           in_taken;
	int           frames_sent, frames_taken;
	int           src_idle_pct, snk_stall_pct;
	int           sink_hold;
	int           mismatches;
	int           idle_cycles;

	gait_phase_terrain_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [PCT_W-1:0] share_pct(longint unsigned part, longint unsigned total);
		longint unsigned p;
		if (total == 0)
			return '0;
		p = (part * 100) / total;
		return (p > PCT_FULL) ? PCT_FULL : PCT_W'(p);
	endfunction

	// Classify one frame, advance the shadow counters and return the result beat it causes
	function automatic gait_result_t classify_frame(foot_frame_t fr);
		gait_result_t    r;
		int unsigned     front_avg, mid_avg, back_avg;
		bit              front_up, mid_up, back_up;
		longint unsigned total;
		r = '0;
		front_avg = (int'(fr[0]) + int'(fr[1]) + int'(fr[2])) / 3;
		mid_avg   = (int'(fr[3]) + int'(fr[4])) / 2;
		back_avg  = (int'(fr[5]) + int'(fr[6]) + int'(fr[7])) / 3;
		front_up  = front_avg > thr_model;
		mid_up    = mid_avg > thr_model;
		back_up   = back_avg > thr_model;

		// once front and middle are not both unloaded, a loaded heel means stance
		if (front_up && mid_up && back_up)
			r.phase = PH_SWING;
		else if (front_up && mid_up)
			r.phase = PH_HEEL_STRIKE;
		else if (!back_up)
			r.phase = PH_STANCE;
		else
			r.phase = PH_HEEL_OFF;

		// bump the phase counter, holding at full scale
		case (r.phase)
			PH_SWING:       if (swing_cnt != '1) swing_cnt++;
			PH_HEEL_STRIKE: if (heel_strike_cnt != '1) heel_strike_cnt++;
			PH_STANCE:      if (stance_cnt != '1) stance_cnt++;
			default:        if (heel_off_cnt != '1) heel_off_cnt++;
		endcase
		if (r.phase != PH_SWING)
			grounded_seen = 1'b1;

		total = longint'(stance_cnt) + longint'(heel_off_cnt) + longint'(swing_cnt)
			+ longint'(heel_strike_cnt);

		// a swing after ground contact closes the window once it is long enough
		if (r.phase == PH_SWING && grounded_seen && total > longint'(min_window_model)) begin
			r.decided         = 1'b1;
			r.swing_pct       = share_pct(swing_cnt, total);
			r.stance_pct      = share_pct(stance_cnt, total);
			r.heel_off_pct    = share_pct(heel_off_cnt, total);
			r.heel_strike_pct = share_pct(heel_strike_cnt, total);
			if (r.swing_pct > SWING_LOW && r.swing_pct < SWING_HIGH) begin
				if (r.heel_strike_pct < STRIKE_NONE && r.heel_off_pct > HEEL_OFF_MIN)
					r.terrain = TR_DESCENDING;
				else if (r.heel_strike_pct < STRIKE_MAX)
					r.terrain = (r.stance_pct > r.heel_off_pct &&
						r.stance_pct - r.heel_off_pct > STANCE_MARGIN) ? TR_ASCENDING : TR_LEVEL;
				else
					r.terrain = TR_UNDECIDED;
			end else begin
				r.terrain = TR_OUT_OF_BAND;
			end
			r.window_count  = (total > longint'(24'hFFFFFF)) ? 24'hFFFFFF : WIN_W'(total);
			grounded_seen   = 1'b0;
			stance_cnt      = '0;
			heel_off_cnt    = '0;
			swing_cnt       = '0;
			heel_strike_cnt = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Frame builders
	// ------------------------------------------------------------------

	// Draw a sample that keeps its region on the chosen side of the threshold;
	// tight draws stay within a few codes of it
	function automatic logic [SAMPLE_W-1:0] pick_sample(bit up, bit tight);
		int unsigned lo, hi;
		if (up && thr_model != SAMPLE_MAX) begin
			lo = thr_model + 1;
			hi = (tight && thr_model < SAMPLE_MAX - 3) ? thr_model + 3 : SAMPLE_MAX;
		end else begin
			hi = thr_model;
			lo = (tight && thr_model > 2) ? thr_model - 2 : 0;
		end
		return SAMPLE_W'($urandom_range(hi, lo));
	endfunction

	function automatic foot_frame_t make_frame(logic [PHASE_W-1:0] ph);
		foot_frame_t fr;
		logic [2:0]  unloaded;  // {back, middle, front}
		bit          tight;
		int          region;
		case (ph)
			PH_SWING:       unloaded = 3'b111;
			PH_HEEL_STRIKE: unloaded = 3'b011;
			default: begin
				// front and middle never both unloaded here
				unloaded[1:0] = 2'($urandom_range(2));
				unloaded[2]   = (ph == PH_HEEL_OFF);
			end
		endcase
		tight = ($urandom_range(3) == 0);
		for (int i = 0; i < 8; i++) begin
			region = (i < 3) ? 0 : (i < 5) ? 1 : 2;
			fr[i]  = pick_sample(unloaded[region], tight);
		end
		return fr;
	endfunction

	function automatic foot_frame_t flat_frame(logic [SAMPLE_W-1:0] f, logic [SAMPLE_W-1:0] m,
		logic [SAMPLE_W-1:0] b);
		return {b, b, b, m, m, f, f, f};
	endfunction

	// ------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------

	// Queue one frame for the driver and hold until its beat is taken
	task automatic send_frame(foot_frame_t fr);
		frames_out.push_back(fr);
		frames_sent++;
		wait (frames_taken == frames_sent);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD:  thr_model = value[THR_W-1:0];
			REG_MIN_WINDOW: min_window_model = value[WIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold off until every expected beat is back, then let the divider settle
	task automatic drain_pipeline();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One gait window: leading swings, shuffled ground-contact frames, mostly a closing swing
	task automatic walk_window();
		logic [PHASE_W-1:0] steps[$];
		logic [PHASE_W-1:0] swap;
		int                 lead, i, j;
		lead = $urandom_range(8);
		repeat ($urandom_range(10)) steps.push_back(PH_STANCE);
		repeat ($urandom_range(6)) steps.push_back(PH_HEEL_OFF);
		if ($urandom_range(1) == 1)
			repeat ($urandom_range(4)) steps.push_back(PH_HEEL_STRIKE);
		for (i = steps.size() - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			swap     = steps[i];
			steps[i] = steps[j];
			steps[j] = swap;
		end
		repeat (lead) send_frame(make_frame(PH_SWING));
		foreach (steps[k])
			send_frame(make_frame(steps[k]));
		// leave a few windows open so the next one runs on
		if ($urandom_range(9) != 0)
			send_frame(make_frame(PH_SWING));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every phase, the threshold boundary and every terrain class but level
	task automatic check_corner_frames();
		foot_frame_t fr;
		src_idle_pct  = 0;
		snk_stall_pct = 0;

		// reset settings: each phase at least once, no window can close yet
		send_frame(flat_frame(12'd0, 12'd0, 12'd0));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'd0));
		send_frame(flat_frame(12'd0, 12'd0, 12'hFFF));
		send_frame(flat_frame(12'd0, 12'hFFF, 12'd0));

		// junk in the upper write bits must be masked off the threshold
		drain_pipeline();
		write_reg(REG_THRESHOLD, {12'hFFF, THR_MID});
		write_reg(REG_MIN_WINDOW, '0);

		// swing closes the running window with a large heel-strike share: undecided
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));

		// averages that truncate down onto the threshold count as loaded
		fr    = flat_frame(THR_MID, THR_MID, 12'hFFF);
		fr[2] = THR_MID + 12'd1;
		fr[3] = THR_MID + 12'd1;
		send_frame(fr);
		fr    = flat_frame(THR_MID + 12'd1, THR_MID + 12'd1, THR_MID + 12'd1);
		fr[7] = THR_MID;
		send_frame(fr);
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));

		// swing with the flag clear only counts; then a descending window
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));
		send_frame(flat_frame(12'd0, 12'd0, 12'hFFF));
		send_frame(flat_frame(12'd0, 12'd0, 12'd0));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));

		// half stance, half swing: ascending
		send_frame(flat_frame(12'd0, 12'd0, 12'd0));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));

		// swing share of a quarter: out of band
		repeat (3) send_frame(flat_frame(12'd0, 12'd0, 12'd0));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));

		// lowest threshold with the longest window: any nonzero average is unloaded
		drain_pipeline();
		write_reg(REG_THRESHOLD, '0);
		write_reg(REG_MIN_WINDOW, 24'hFFFFFF);
		send_frame(flat_frame(12'd0, 12'd0, 12'd0));
		send_frame(flat_frame(12'd1, 12'd1, 12'd1));

		// highest threshold: nothing can be unloaded
		drain_pipeline();
		write_reg(REG_THRESHOLD, 24'(SAMPLE_MAX));
		send_frame(flat_frame(12'hFFF, 12'hFFF, 12'hFFF));
	endtask

	// Random gait windows with some noise frames under one idling pattern
	task automatic run_gait_traffic(int src_pct, int snk_pct, logic [THR_W-1:0] thr);
		foot_frame_t fr;
		int          start;
		drain_pipeline();
		write_reg(REG_THRESHOLD, 24'(thr));
		write_reg(REG_MIN_WINDOW, 24'($urandom_range(20)));
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		start         = frames_sent;
		while (frames_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				foreach (fr[i])
					fr[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
				send_frame(fr);
			end else begin
				walk_window();
			end
		end
	endtask

	// Hold the receiver off long enough to fill the block and stall its input,
	// then pause the sender until everything has drained
	task automatic check_output_backpressure();
		int start;
		drain_pipeline();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		sink_hold     = LONG_HOLD;
		start         = frames_sent;
		while (frames_sent - start < 40)
			walk_window();
		drain_pipeline();
	endtask

	// ------------------------------------------------------------------
	// Frame driver: change at the falling edge, hold a beat until it is taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (frames_out.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				frame_on_bus = frames_out.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= frame_on_bus;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (sink_hold != 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: predict on each input beat, check each result beat, watch for hangs
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		gait_result_t want, got;
		bit           out_taken;
		in_taken  = s_tvalid && s_tready;
		out_taken = m_tvalid && m_tready;
		if (out_taken) begin
			got = gait_result_t'(m_tdata[OUT_USED_W-1:0]);
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				compare_field("phase", want.phase, got.phase);
				compare_field("decision_valid", want.decided, got.decided);
				compare_field("terrain", want.terrain, got.terrain);
				compare_field("swing_pct", want.swing_pct, got.swing_pct);
				compare_field("stance_pct", want.stance_pct, got.stance_pct);
				compare_field("heel_off_pct", want.heel_off_pct, got.heel_off_pct);
				compare_field("heel_strike_pct", want.heel_strike_pct, got.heel_strike_pct);
				compare_field("window_count", want.window_count, got.window_count);
			end
		end
		if (in_taken) begin
			pending_results.push_back(classify_frame(frame_on_bus));
			frames_taken++;
		end
		if (in_taken || out_taken) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					idle_cycles, pending_results.size());
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		thr_model        = THRESHOLD_RESET;
		min_window_model = MIN_WINDOW_RESET;
		stance_cnt       = '0;
		heel_off_cnt     = '0;
		swing_cnt        = '0;
		heel_strike_cnt  = '0;
		grounded_seen    = 1'b0;
		src_idle_pct     = 0;
		snk_stall_pct    = 0;
		sink_hold        = 0;
		mismatches       = 0;
		idle_cycles      = 0;
		frames_sent      = 0;
		frames_taken     = 0;

		// hold reset, then release away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_corner_frames();
		run_gait_traffic(0, 0, THRESHOLD_RESET);
		check_output_backpressure();
		run_gait_traffic(61, 0, THR_W'($urandom_range(3000, 500)));
		run_gait_traffic(0, 61, THR_W'($urandom_range(SAMPLE_MAX - 1, 1)));
		run_gait_traffic(18, 18, THR_W'($urandom_range(SAMPLE_MAX - 1, 1)));

		drain_pipeline();
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
